[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the top-level detector.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/core/afd_pkg.sv]
// ---------------------------------------------------------------------------
// afd_pkg
// Types, constants and helpers of the accelerometer fall detector.
// ---------------------------------------------------------------------------
package afd_pkg;

  // Axis code width and derived datapath widths
  localparam int AXIS_BITS = 6;
  localparam int SUM_W     = 2 * AXIS_BITS;        // sum of three squares fits here
  localparam int MAG_W     = 6;
  localparam int THR_W     = 6;
  localparam int SLOT_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CNT_W     = $clog2(AXIS_BITS);

  // Configuration register reset values
  localparam logic [THR_W-1:0]  THR_RESET       = THR_W'(5);
  localparam logic [SLOT_W-1:0] SLOT_LAST_RESET = SLOT_W'(119);

  // Configuration register indexes
  typedef enum logic {
    CFG_FALL_THRESHOLD = 1'b0,
    CFG_SLOT_LAST      = 1'b1
  } cfg_idx_t;

  // Axis select codes for the squaring pass
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_sel_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DECIDE
  } state_t;

  // Control from the sequencer to the magnitude unit
  typedef struct packed {
    logic      load;
    logic      square;
    logic      root_step;
    axis_sel_t axis_sel;
  } mag_ctrl_t;

  // One result item
  typedef struct packed {
    logic              fallen;
    logic [SLOT_W-1:0] slot;
    logic [MAG_W-1:0]  magnitude;
    logic [MAG_W-1:0]  change;
  } result_t;

  // Magnitude of a sign-extended two's complement code
  function automatic logic [AXIS_BITS-1:0] axis_abs(input logic [AXIS_BITS-1:0] v);
    if (v[AXIS_BITS-1]) begin
      return ~v + AXIS_BITS'(1);
    end
    return v;
  endfunction

endpackage

[rtl/core/afd_channels.sv]
// ---------------------------------------------------------------------------
// afd_channels
// Valid/ready channels for sample requests and detector results.
// ---------------------------------------------------------------------------
interface afd_in_if
  import afd_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [AXIS_BITS-1:0] x_raw;
  logic [AXIS_BITS-1:0] y_raw;
  logic [AXIS_BITS-1:0] z_raw;

  modport source (output valid, x_raw, y_raw, z_raw, input ready);
  modport sink   (input valid, x_raw, y_raw, z_raw, output ready);
endinterface

interface afd_out_if
  import afd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              fallen;
  logic [SLOT_W-1:0] slot;
  logic [MAG_W-1:0]  magnitude;
  logic [MAG_W-1:0]  change;

  modport source (output valid, fallen, slot, magnitude, change, input ready);
  modport sink   (input valid, fallen, slot, magnitude, change, output ready);
endinterface

[rtl/core/accel_magnitude_fall_detector.sv]
// ---------------------------------------------------------------------------
// accel_magnitude_fall_detector
// Three-axis magnitude and change detector with a fall flag and slot count.
// ---------------------------------------------------------------------------
//   channel | direction | carries
//   --------+-----------+---------------------------------------------
//   in_chan | sink      | x_raw, y_raw, z_raw sample request
//   out_chan| source    | fallen, slot, magnitude, change
//   cfg_*   | write     | fall_threshold (0), slot_last (1)
//
// Each sample passes from the idle state, which takes the request, through
// the multiply-accumulate steps, one per axis, and the root steps, one root
// bit per cycle, in the shared magnitude unit, then the decide state, and
// only then back to idle for the next request. The first sample after reset
// produces no result.
// Results wait in an output register; the block only stalls in the decide
// cycle when that register is still full. Reset is synchronous, active low;
// ready stays low while reset is held.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module accel_magnitude_fall_detector
  import afd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  afd_in_if.sink           in_chan,
  afd_out_if.source        out_chan,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  mag_ctrl_t        mag_ctrl;
  logic [MAG_W-1:0] magnitude;
  logic             emit;
  logic             commit;
  logic             out_free;
  result_t          result;
  result_t          out_r;
  logic             out_valid_r;

  // Magnitude unit
  afd_mag_unit u_mag (
    .clk       (clk),
    .ctrl      (mag_ctrl),
    .x_raw     (in_chan.x_raw),
    .y_raw     (in_chan.y_raw),
    .z_raw     (in_chan.z_raw),
    .magnitude (magnitude)
  );

  // Decision and state
  afd_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .commit    (commit),
    .magnitude (magnitude),
    .emit      (emit),
    .result    (result)
  );

  assign out_free = !out_valid_r || out_chan.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (cnt_r == CNT_W'(AXIS_Z)) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (cnt_r == CNT_W'(AXIS_BITS - 1)) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!emit || out_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  // Step counter, cleared between phases
  always_comb begin
    cnt_nxt = '0;
    if ((state_r == ST_SQUARE || state_r == ST_ROOT) && state_nxt == state_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // Outputs of the sequencer
  always_comb begin
    mag_ctrl           = '0;
    mag_ctrl.axis_sel  = axis_sel_t'(cnt_r[1:0]);
    in_chan.ready      = 1'b0;
    commit             = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = rst_n;
        mag_ctrl.load = in_chan.valid && rst_n;
      end
      ST_SQUARE: mag_ctrl.square    = 1'b1;
      ST_ROOT:   mag_ctrl.root_step = 1'b1;
      ST_DECIDE: commit             = !emit || out_free;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && emit) begin
      out_r <= result;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.fallen    = out_r.fallen;
  assign out_chan.slot      = out_r.slot;
  assign out_chan.magnitude = out_r.magnitude;
  assign out_chan.change    = out_r.change;

  // Checks
  `ASSERT_PROP(a_busy_after_accept, clk, rst_n, in_chan.valid && in_chan.ready |=> !in_chan.ready)
  `ASSERT_PROP(a_out_from_decide, clk, rst_n, $rose(out_valid_r) |-> $past(state_r) == ST_DECIDE)
  `ASSERT_NEVER(a_cnt_range, clk, rst_n, state_r == ST_ROOT && cnt_r > CNT_W'(AXIS_BITS - 1))

endmodule

[rtl/core/afd_mag_unit.sv]
// ---------------------------------------------------------------------------
// afd_mag_unit
// Iterative magnitude unit: squares and sums the axes one per cycle, then
// takes the integer square root one result bit per cycle.
// ---------------------------------------------------------------------------
module afd_mag_unit
  import afd_pkg::*;
(
  input  logic                 clk,
  input  mag_ctrl_t            ctrl,
  input  logic [AXIS_BITS-1:0] x_raw,
  input  logic [AXIS_BITS-1:0] y_raw,
  input  logic [AXIS_BITS-1:0] z_raw,
  output logic [MAG_W-1:0]     magnitude
);

  localparam logic [SUM_W-1:0] BIT_START = SUM_W'(1) << (SUM_W - 2);

  logic [AXIS_BITS-1:0] ax_r, ay_r, az_r;
  logic [SUM_W-1:0]     n_r, n_nxt;
  logic [SUM_W-1:0]     root_r, root_nxt;
  logic [SUM_W-1:0]     bit_r, bit_nxt;
  logic [AXIS_BITS-1:0] operand;
  logic [SUM_W-1:0]     product;
  logic [SUM_W:0]       trial;

  // Operand select for the squaring pass
  always_comb begin
    case (ctrl.axis_sel)
      AXIS_X:  operand = ax_r;
      AXIS_Y:  operand = ay_r;
      default: operand = az_r;
    endcase
  end

  assign product = operand * operand;
  assign trial   = {1'b0, root_r} + {1'b0, bit_r};

  // Shared add/compare step
  always_comb begin
    n_nxt    = n_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    if (ctrl.load) begin
      n_nxt    = '0;
      root_nxt = '0;
      bit_nxt  = BIT_START;
    end else if (ctrl.square) begin
      n_nxt = n_r + product;
    end else if (ctrl.root_step) begin
      bit_nxt = bit_r >> 2;
      if ({1'b0, n_r} >= trial) begin
        n_nxt    = n_r - trial[SUM_W-1:0];
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ax_r <= axis_abs(x_raw);
      ay_r <= axis_abs(y_raw);
      az_r <= axis_abs(z_raw);
    end
    n_r    <= n_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign magnitude = root_r[MAG_W-1:0];

endmodule

[rtl/core/afd_decide.sv]
// ---------------------------------------------------------------------------
// afd_decide
// Configuration registers, previous magnitude, slot counter and the fall
// decision for each finished magnitude.
// ---------------------------------------------------------------------------
module afd_decide
  import afd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             commit,
  input  logic [MAG_W-1:0] magnitude,
  output logic             emit,
  output result_t          result
);

  logic [THR_W-1:0]  thr_r;
  logic [SLOT_W-1:0] slot_last_r;
  logic [MAG_W-1:0]  prev_r;
  logic              have_prev_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [MAG_W-1:0]  change;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      slot_last_r <= SLOT_LAST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FALL_THRESHOLD: thr_r       <= cfg_data[THR_W-1:0];
        CFG_SLOT_LAST:      slot_last_r <= cfg_data[SLOT_W-1:0];
      endcase
    end
  end

  // Absolute change and threshold compare
  assign change = (magnitude >= prev_r) ? magnitude - prev_r : prev_r - magnitude;

  always_comb begin
    result.fallen    = change > thr_r;
    result.slot      = slot_r;
    result.magnitude = magnitude;
    result.change    = change;
  end

  assign emit = have_prev_r;

  // Slot counter wraps after the last value
  assign slot_nxt = (slot_r != slot_last_r) ? slot_r + SLOT_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      slot_r      <= '0;
    end else if (commit) begin
      prev_r      <= magnitude;
      have_prev_r <= 1'b1;
      if (have_prev_r) begin
        slot_r <= slot_nxt;
      end
    end
  end

endmodule
